>>> rtl/dtfe_pkg.sv
// Shared types, codes, constants and table functions for the date/time field editor.
package dtfe_pkg;

  // Field widths
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WDAY_W    = 3;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int CUR_W     = 3;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Event codes carried in the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_MODE = 2'd1,
    FUNC_UP   = 2'd2,
    FUNC_DOWN = 2'd3
  } func_t;

  // Cursor positions
  typedef enum logic [CUR_W-1:0] {
    CUR_YEAR    = 3'd0,
    CUR_MONTH   = 3'd1,
    CUR_DAY     = 3'd2,
    CUR_WEEKDAY = 3'd3,
    CUR_HOUR    = 3'd4,
    CUR_MINUTE  = 3'd5,
    CUR_SECOND  = 3'd6,
    CUR_SAVE    = 3'd7
  } cursor_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_HIGH = 2'd1;

  // Reset values
  localparam logic [YEAR_W-1:0]  YEAR_LOW_RESET  = 14'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_HIGH_RESET = 14'd2099;
  localparam logic [YEAR_W-1:0]  YEAR_RESET      = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_RESET     = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_RESET       = 5'd1;
  localparam logic [WDAY_W-1:0]  WDAY_RESET      = 3'd1;

  // Field limits
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
  localparam logic [WDAY_W-1:0]  WDAY_MIN  = 3'd1;
  localparam logic [WDAY_W-1:0]  WDAY_MAX  = 3'd7;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;

  // Edit register set
  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [WDAY_W-1:0]  weekday;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dtfe_fields_t;

  // Year wrap limits
  typedef struct packed {
    logic [YEAR_W-1:0] low;
    logic [YEAR_W-1:0] high;
  } dtfe_limits_t;

  // One result item
  typedef struct packed {
    logic         save_pulse;
    dtfe_fields_t fields;
    cursor_t      cursor;
  } dtfe_result_t;

  // Month length; Feb is 29 when year mod 4 is 0, invalid months count 31
  function automatic logic [DAY_W-1:0] days_of(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // (13 * (m + 1)) / 5 for the adjusted month
  function automatic logic [5:0] month_term(logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd0:    t = 6'd2;
      4'd1:    t = 6'd5;
      4'd2:    t = 6'd7;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd41;
    endcase
    return t;
  endfunction

  // Wrap step: up past hi gives lo, down past lo gives hi
  function automatic logic [YEAR_W-1:0] step_wrap(logic [YEAR_W-1:0] v, logic [YEAR_W-1:0] lo,
                                                  logic [YEAR_W-1:0] hi, logic up);
    logic [YEAR_W-1:0] r;
    if (up) begin
      r = (v >= hi) ? lo : v + 14'd1;
    end else begin
      r = (v <= lo) ? hi : v - 14'd1;
    end
    return r;
  endfunction

endpackage

>>> rtl/clock_date_time_field_editor_core.sv
// Top level of the date/time field editor: stream ports, input and result registers, config.
//
// Button-driven editor for a clock's date and time. Each input item is one event selected by
// in_tuser (load current time, mode, up, down) and gives exactly one result item with the
// cursor, all edited fields and a save pulse. An item enters an input register, is processed
// by combinational next-value logic against the edit registers, and lands in a result register:
// one item per clock is sustained while out_tready is high; out_tvalid rises with that write.
// The input side keeps accepting while a result waits, until both registers hold items. The
// year wrap limits are written through the cfg port (index 0 low limit, index 1 high limit;
// other indexes are ignored), which is always ready and should be written only while idle.
module clock_date_time_field_editor_core
  import dtfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata from bit 0: load_year[14], load_month[4], load_day[5], load_weekday[3],
  // load_hour[5], load_minute[6], load_second[6], zero pad[5]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func[2]
  input  logic [FUNC_W-1:0]     in_tuser,
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata from bit 0: cursor[3], year[14], month[4], day[5], weekday[3], hour[5],
  // minute[6], second[6], zero pad[2]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: save_pulse[1]
  output logic                  out_tuser,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [YEAR_W-1:0]     cfg_data
);

  logic         s1_valid_r;
  func_t        s1_func_r;
  dtfe_fields_t s1_load_r;
  logic         out_valid_r;
  dtfe_result_t out_result_r;
  dtfe_limits_t limits_r;
  dtfe_result_t result;
  logic         step_en;

  // Handshake: process when the result register is free or being drained
  assign step_en   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step_en;
  assign cfg_ready = 1'b1;

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r         <= func_t'(in_tuser);
      s1_load_r.year    <= in_tdata[13:0];
      s1_load_r.month   <= in_tdata[17:14];
      s1_load_r.day     <= in_tdata[22:18];
      s1_load_r.weekday <= in_tdata[25:23];
      s1_load_r.hour    <= in_tdata[30:26];
      s1_load_r.minute  <= in_tdata[36:31];
      s1_load_r.second  <= in_tdata[42:37];
    end
  end

  // Year limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.low  <= YEAR_LOW_RESET;
      limits_r.high <= YEAR_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_YEAR_LOW)  limits_r.low  <= cfg_data;
      if (cfg_index == CFG_YEAR_HIGH) limits_r.high <= cfg_data;
    end
  end

  dtfe_editor u_editor (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .func    (s1_func_r),
    .load    (s1_load_r),
    .limits  (limits_r),
    .result  (result)
  );

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_result_r.save_pulse;
  assign out_tdata  = {2'b00,
                       out_result_r.fields.second,
                       out_result_r.fields.minute,
                       out_result_r.fields.hour,
                       out_result_r.fields.weekday,
                       out_result_r.fields.day,
                       out_result_r.fields.month,
                       out_result_r.fields.year,
                       out_result_r.cursor};

endmodule

>>> rtl/dtfe_weekday.sv
// Weekday from a Gregorian date by Zeller's congruence, constant-divisor logic only.
module dtfe_weekday
  import dtfe_pkg::*;
(
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output logic [WDAY_W-1:0]  weekday
);

  // ceil(2^17 / 25): exact floor(q / 25) for q below 2^15
  localparam int          RECIP_SHIFT = 17;
  localparam logic [12:0] RECIP25     = 13'd5243;
  localparam logic [14:0] YEAR_OFFSET = 15'd400;

  logic              early;
  logic [MONTH_W-1:0] m_adj;
  logic [14:0]       yy;
  logic [12:0]       q4;
  logic [25:0]       prod;
  logic [8:0]        q100;
  logic [6:0]        q400;
  logic [14:0]       sum;
  logic [5:0]        fold1;
  logic [3:0]        fold2;
  logic [2:0]        h;

  // Jan and Feb count as months 13 and 14 of the year before
  assign early = (month < 4'd3);
  assign m_adj = early ? month + 4'd12 : month;
  assign yy    = {1'b0, year} + YEAR_OFFSET - {14'd0, early};

  // yy/4, yy/100 = (yy/4)/25, yy/400 = (yy/100)/4
  assign q4   = yy[14:2];
  assign prod = 26'(q4) * 26'(RECIP25);
  assign q100 = prod[RECIP_SHIFT+8:RECIP_SHIFT];
  assign q400 = q100[8:2];

  assign sum = 15'(day) + 15'(month_term(m_adj)) + yy + 15'(q4) - 15'(q100) + 15'(q400);

  // mod 7 by folding octal digits (8 is 1 mod 7)
  assign fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9]) + 6'(sum[14:12]);
  assign fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
  assign h     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  // Zeller h = 0 is Saturday; map to 1 = Monday .. 7 = Sunday
  always_comb begin
    case (h)
      3'd0:    weekday = 3'd6;
      3'd1:    weekday = 3'd7;
      default: weekday = h - 3'd1;
    endcase
  end

endmodule

>>> rtl/dtfe_editor.sv
// Edit registers, cursor and the per-event next-value logic.
module dtfe_editor
  import dtfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  func_t        func,
  input  dtfe_fields_t load,
  input  dtfe_limits_t limits,
  output dtfe_result_t result
);

  cursor_t          cursor_r, cursor_nxt;
  dtfe_fields_t     fields_r, fields_nxt;
  logic             pulse;
  logic             up;
  logic [DAY_W-1:0] load_lim;
  logic [DAY_W-1:0] load_day;
  logic [DAY_W-1:0] cur_lim;
  logic [DAY_W-1:0] step_lim;
  logic [WDAY_W-1:0] calc_wday;

  // Load path: clamp the day, then recompute weekday if it is invalid
  assign load_lim = days_of(load.year, load.month);
  assign load_day = (load.day > load_lim) ? load_lim : load.day;

  dtfe_weekday u_weekday (
    .year    (load.year),
    .month   (load.month),
    .day     (load_day),
    .weekday (calc_wday)
  );

  assign up      = (func == FUNC_UP);
  assign cur_lim = days_of(fields_r.year, fields_r.month);

  // Next state for one event
  always_comb begin
    fields_nxt = fields_r;
    cursor_nxt = cursor_r;
    pulse      = 1'b0;
    step_lim   = '0;
    case (func)
      FUNC_LOAD: begin
        fields_nxt     = load;
        fields_nxt.day = load_day;
        if (load.weekday == 3'd0) begin
          fields_nxt.weekday = calc_wday;
        end
        cursor_nxt = CUR_YEAR;
      end
      FUNC_MODE: begin
        if (cursor_r == CUR_SAVE) begin
          pulse = 1'b1;
        end else begin
          cursor_nxt = cursor_t'(cursor_r + 3'd1);
        end
      end
      default: begin
        case (cursor_r)
          CUR_YEAR: begin
            fields_nxt.year = step_wrap(fields_r.year, limits.low, limits.high, up);
            step_lim = days_of(fields_nxt.year, fields_r.month);
            if (fields_r.day > step_lim) fields_nxt.day = step_lim;
          end
          CUR_MONTH: begin
            fields_nxt.month = MONTH_W'(step_wrap(14'(fields_r.month), 14'(MONTH_MIN),
                                                  14'(MONTH_MAX), up));
            step_lim = days_of(fields_r.year, fields_nxt.month);
            if (fields_r.day > step_lim) fields_nxt.day = step_lim;
          end
          CUR_DAY: begin
            fields_nxt.day = DAY_W'(step_wrap(14'(fields_r.day), 14'(DAY_MIN),
                                              14'(cur_lim), up));
          end
          CUR_WEEKDAY: begin
            fields_nxt.weekday = WDAY_W'(step_wrap(14'(fields_r.weekday), 14'(WDAY_MIN),
                                                   14'(WDAY_MAX), up));
          end
          CUR_HOUR: begin
            fields_nxt.hour = HOUR_W'(step_wrap(14'(fields_r.hour), 14'd0,
                                                14'(HOUR_MAX), up));
          end
          CUR_MINUTE: begin
            fields_nxt.minute = MIN_W'(step_wrap(14'(fields_r.minute), 14'd0,
                                                 14'(MIN_MAX), up));
          end
          CUR_SECOND: begin
            fields_nxt.second = SEC_W'(step_wrap(14'(fields_r.second), 14'd0,
                                                 14'(SEC_MAX), up));
          end
          default: begin
            // save position: up and down change nothing
          end
        endcase
      end
    endcase
  end

  // Edit state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r         <= CUR_YEAR;
      fields_r.year    <= YEAR_RESET;
      fields_r.month   <= MONTH_RESET;
      fields_r.day     <= DAY_RESET;
      fields_r.weekday <= WDAY_RESET;
      fields_r.hour    <= '0;
      fields_r.minute  <= '0;
      fields_r.second  <= '0;
    end else if (step_en) begin
      cursor_r <= cursor_nxt;
      fields_r <= fields_nxt;
    end
  end

  assign result.cursor     = cursor_nxt;
  assign result.fields     = fields_nxt;
  assign result.save_pulse = pulse;

endmodule
